/* src/dsc_pkg.sv */
package dsc_pkg;

  typedef enum logic [3:0] {
    REQ_CTRL_WR = 4'd0,
    REQ_CTRL_RD = 4'd1,
    REQ_DATA_WR = 4'd2,
    REQ_DATA_RD = 4'd3,
    REQ_RX_BYTE = 4'd4,
    REQ_TX_DONE = 4'd5,
    REQ_CTS     = 4'd6,
    REQ_DCD     = 4'd7,
    REQ_ACK     = 4'd8,
    REQ_RETI    = 4'd9
  } req_t;

  // WR0 command field, bits 5:3
  typedef enum logic [2:0] {
    CMD_NULL         = 3'd0,
    CMD_RESET_STATUS = 3'd2,
    CMD_CHAN_RESET   = 3'd3,
    CMD_RX_NEXT      = 3'd4,
    CMD_RESET_TX     = 3'd5,
    CMD_RESET_ERR    = 3'd6
  } cmd_t;

  localparam logic [2:0] REG_WR0 = 3'd0;
  localparam logic [2:0] REG_WR1 = 3'd1;
  localparam logic [2:0] REG_WR2 = 3'd2;
  localparam logic [2:0] REG_WR3 = 3'd3;
  localparam logic [2:0] REG_WR5 = 3'd5;

  // WR1 receive interrupt mode: interrupt on first byte after arming
  localparam logic [1:0] RXM_NEXT = 2'd1;

  // source offset within a channel; channel A sources sit at 4..7
  localparam logic [1:0] OFF_TX = 2'd0;
  localparam logic [1:0] OFF_ST = 2'd1;
  localparam logic [1:0] OFF_RX = 2'd2;
  localparam logic [1:0] OFF_ER = 2'd3;

  localparam int NUM_SRC = 8;

  // daisy chain: A rx, A tx, A status, A error, B rx, B tx, B status, B error
  localparam logic [2:0] PRIO_ORDER [NUM_SRC] = '{
    3'd6, 3'd4, 3'd5, 3'd7, 3'd2, 3'd0, 3'd1, 3'd3
  };

  // bits of the write registers that the logic uses
  typedef struct packed {
    logic [2:0] ptr;
    logic [1:0] rx_mode;   // WR1 4:3
    logic       tx_ie;     // WR1 1
    logic       ext_ie;    // WR1 0
    logic       rx_en;     // WR3 0
    logic       dtr;       // WR5 7
    logic       brk;       // WR5 4
    logic       tx_en;     // WR5 3
    logic       rts;       // WR5 1
  } chan_cfg_t;

  // stored RR0 bits that can be nonzero
  typedef struct packed {
    logic cts;        // bit 5
    logic dcd;        // bit 3
    logic tx_empty;   // bit 2
    logic rx_avail;   // bit 0
  } rr0_t;

  localparam rr0_t RR0_RESET = '{cts: 1'b0, dcd: 1'b0, tx_empty: 1'b1, rx_avail: 1'b0};

  typedef struct packed {
    logic       irq;
    logic       pend_hit;
    logic [2:0] pend_src;
    logic       serv_hit;
    logic [2:0] serv_src;
  } prio_t;

  typedef struct packed {
    logic [2:0] modem_levels;
    logic [2:0] modem_changed;
    logic [7:0] tx_byte;
    logic       tx_strobe;
    logic       ack_found;
    logic       irq_request;
    logic [7:0] read_data;
  } res_t;

endpackage

/* src/dsc_prio.sv */
module dsc_prio (
  input  logic [7:0]     pend,
  input  logic [7:0]     serv,
  output dsc_pkg::prio_t pr
);
  import dsc_pkg::*;

  always_comb begin
    logic [2:0] s;
    logic       stop;
    pr   = '0;
    stop = 1'b0;
    for (int i = 0; i < NUM_SRC; i++) begin
      s = PRIO_ORDER[i];
      // irq line: first in-service source blocks everything below it
      if (!stop) begin
        if (serv[s]) begin
          stop = 1'b1;
        end else if (pend[s]) begin
          pr.irq = 1'b1;
          stop   = 1'b1;
        end
      end
      if (!pr.pend_hit && pend[s]) begin
        pr.pend_hit = 1'b1;
        pr.pend_src = s;
      end
      if (!pr.serv_hit && serv[s]) begin
        pr.serv_hit = 1'b1;
        pr.serv_src = s;
      end
    end
  end

endmodule

/* src/dsc_engine.sv */
module dsc_engine (
  input  logic           clk,
  input  logic           rst,
  input  logic           go,
  input  dsc_pkg::req_t  req,
  input  logic           ch,
  input  logic [7:0]     d,
  input  logic           lvl,
  output dsc_pkg::res_t  res
);
  import dsc_pkg::*;

  chan_cfg_t  cfg [2];
  chan_cfg_t  cfg_next [2];
  rr0_t       rr0 [2];
  rr0_t       rr0_next [2];
  logic [7:0] pend, pend_next;
  logic [7:0] serv, serv_next;
  logic [1:0] armed, armed_next;
  logic [7:0] rx_hold [2];
  logic [7:0] rx_hold_next [2];
  logic [7:0] tx_hold [2];
  logic [7:0] tx_hold_next [2];
  logic [7:0] wr2b, wr2b_next;   // channel B WR2, the vector base

  prio_t pr_cur, pr_next;

  dsc_prio u_prio_cur (.pend(pend), .serv(serv), .pr(pr_cur));
  dsc_prio u_prio_next (.pend(pend_next), .serv(serv_next), .pr(pr_next));

  always_comb begin
    chan_cfg_t  cur;
    rr0_t       st;
    logic [2:0] s_tx, s_st, s_rx, s_er;
    logic [7:0] chan_mask;
    logic [7:0] rd;
    logic       found, strobe;
    logic [2:0] mchg;

    cfg_next     = cfg;
    rr0_next     = rr0;
    pend_next    = pend;
    serv_next    = serv;
    armed_next   = armed;
    rx_hold_next = rx_hold;
    tx_hold_next = tx_hold;
    wr2b_next    = wr2b;

    cur       = cfg[ch];
    st        = rr0[ch];
    s_tx      = {~ch, OFF_TX};
    s_st      = {~ch, OFF_ST};
    s_rx      = {~ch, OFF_RX};
    s_er      = {~ch, OFF_ER};
    chan_mask = ch ? 8'h0F : 8'hF0;
    rd        = '0;
    found     = 1'b0;
    strobe    = 1'b0;
    mchg      = '0;

    unique case (req)
      REQ_CTRL_WR: begin
        if (cur.ptr != REG_WR0) begin
          cfg_next[ch].ptr = REG_WR0;
          unique case (cur.ptr)
            REG_WR1: begin
              cfg_next[ch].rx_mode = d[4:3];
              cfg_next[ch].tx_ie   = d[1];
              cfg_next[ch].ext_ie  = d[0];
            end
            REG_WR2: begin
              if (ch) wr2b_next = d;
            end
            REG_WR3: cfg_next[ch].rx_en = d[0];
            REG_WR5: begin
              mchg = {cur.rts ^ d[1], cur.brk ^ d[4], cur.dtr ^ d[7]};
              cfg_next[ch].dtr   = d[7];
              cfg_next[ch].brk   = d[4];
              cfg_next[ch].tx_en = d[3];
              cfg_next[ch].rts   = d[1];
            end
            default: ;
          endcase
        end else begin
          cfg_next[ch].ptr = d[2:0];
          unique case (cmd_t'(d[5:3]))
            CMD_CHAN_RESET: begin
              rr0_next[ch]   = RR0_RESET;
              armed_next[ch] = 1'b0;
              pend_next      = pend & ~chan_mask;
              serv_next      = serv & ~chan_mask;
            end
            CMD_RESET_STATUS: pend_next[s_st] = 1'b0;
            CMD_RX_NEXT:      armed_next[ch]  = 1'b1;
            CMD_RESET_TX:     pend_next[s_tx] = 1'b0;
            CMD_RESET_ERR:    pend_next[s_er] = 1'b0;
            default: ;
          endcase
        end
      end
      REQ_CTRL_RD: begin
        if (cur.ptr == REG_WR0)
          rd = {2'b00, st.cts, 1'b0, st.dcd, st.tx_empty, pr_cur.irq, st.rx_avail};
      end
      REQ_DATA_WR: begin
        if (cur.tx_en) begin
          rr0_next[ch].tx_empty = 1'b0;
          pend_next[s_tx]       = 1'b0;
          tx_hold_next[ch]      = d;
        end
      end
      REQ_DATA_RD: begin
        rr0_next[ch].rx_avail = 1'b0;
        pend_next[s_rx]       = 1'b0;
        rd                    = rx_hold[ch];
      end
      REQ_RX_BYTE: begin
        if (cur.rx_en) begin
          rx_hold_next[ch]      = d;
          rr0_next[ch].rx_avail = 1'b1;
          // mode 1: first byte after arming, modes 2 and 3: every byte
          if ((cur.rx_mode == RXM_NEXT && armed[ch]) || cur.rx_mode[1])
            pend_next[s_rx] = 1'b1;
          armed_next[ch] = 1'b0;
        end
      end
      REQ_TX_DONE: begin
        if (!st.tx_empty) begin
          strobe                = 1'b1;
          rr0_next[ch].tx_empty = 1'b1;
          if (cur.tx_ie) pend_next[s_tx] = 1'b1;
        end
      end
      REQ_CTS: begin
        rr0_next[ch].cts = lvl;
        if ((st.cts != lvl) && cur.ext_ie) pend_next[s_st] = 1'b1;
      end
      REQ_DCD: begin
        rr0_next[ch].dcd = lvl;
        if ((st.dcd != lvl) && cur.ext_ie) pend_next[s_st] = 1'b1;
      end
      REQ_ACK: begin
        rd = wr2b;
        if (pr_cur.pend_hit) begin
          rd                         = wr2b + {4'b0000, pr_cur.pend_src, 1'b0};
          pend_next[pr_cur.pend_src] = 1'b0;
          serv_next[pr_cur.pend_src] = 1'b1;
          found                      = 1'b1;
        end
      end
      REQ_RETI: begin
        if (pr_cur.serv_hit) begin
          serv_next[pr_cur.serv_src] = 1'b0;
          found                      = 1'b1;
        end
      end
      default: ;
    endcase

    res.read_data     = rd;
    res.irq_request   = pr_next.irq;
    res.ack_found     = found;
    res.tx_strobe     = strobe;
    res.tx_byte       = tx_hold_next[ch];
    res.modem_changed = mchg;
    res.modem_levels  = {cfg_next[ch].rts, cfg_next[ch].brk, cfg_next[ch].dtr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg[0]     <= '0;
      cfg[1]     <= '0;
      rr0[0]     <= RR0_RESET;
      rr0[1]     <= RR0_RESET;
      pend       <= '0;
      serv       <= '0;
      armed      <= '0;
      rx_hold[0] <= '0;
      rx_hold[1] <= '0;
      tx_hold[0] <= '0;
      tx_hold[1] <= '0;
      wr2b       <= '0;
    end else if (go) begin
      cfg     <= cfg_next;
      rr0     <= rr0_next;
      pend    <= pend_next;
      serv    <= serv_next;
      armed   <= armed_next;
      rx_hold <= rx_hold_next;
      tx_hold <= tx_hold_next;
      wr2b    <= wr2b_next;
    end
  end

  function automatic logic [7:0] chan_mask_of(input logic c);
    return c ? 8'h0F : 8'hF0;
  endfunction

  // an acked source is in service afterwards
  assert property (@(posedge clk) disable iff (rst)
    go && req == REQ_ACK && pr_cur.pend_hit |=> serv[$past(pr_cur.pend_src)])
    else $error("ack did not mark source in service");

  assert property (@(posedge clk) disable iff (rst)
    go && req == REQ_RETI && pr_cur.serv_hit |=> !serv[$past(pr_cur.serv_src)])
    else $error("reti left source in service");

  assert property (@(posedge clk) disable iff (rst)
    go && req == REQ_CTRL_WR && cfg[ch].ptr == REG_WR0 && d[5:3] == CMD_CHAN_RESET
      |=> (pend & $past(chan_mask_of(ch))) == 8'h00)
    else $error("channel reset left a source pending");

endmodule

/* src/dual_serial_controller_regs_core.sv */
// channel | dir | handshake          | payload
// s       | in  | s_tvalid/s_tready  | s_tuser: req_type, channel; s_tdata: data, line_level
// m       | out | m_tvalid/m_tready  | m_tdata: read_data .. modem_levels
//
// One word per cycle sustained while the output is not stalled; each accepted word is held
// in the input register until the engine processes it, and its result is then registered
// in the output register, which raises m_tvalid.
// The register file and interrupt flags update in the same cycle as that output load.
// rst (synchronous) clears both registers and restores the register model.
// A stalled output holds its word; the input register still takes one more word.
module dual_serial_controller_regs_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [4:0]  s_tuser,   // [3:0] req_type, [4] channel
  input  logic [15:0] s_tdata,   // [7:0] data, [8] line_level, [15:9] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [7:0] read_data, [8] irq_request, [9] ack_found,
                                 // [10] tx_strobe, [18:11] tx_byte,
                                 // [21:19] modem_changed, [24:22] modem_levels, [31:25] zero
);
  import dsc_pkg::*;

  logic       in_valid;
  req_t       in_req;
  logic       in_ch;
  logic [7:0] in_data;
  logic       in_lvl;
  logic       go;
  logic       s_accept;
  res_t       res;

  assign go       = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || go;
  assign s_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_accept) begin
      in_valid <= 1'b1;
    end else if (go) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_req  <= req_t'(s_tuser[3:0]);
      in_ch   <= s_tuser[4];
      in_data <= s_tdata[7:0];
      in_lvl  <= s_tdata[8];
    end
  end

  dsc_engine u_engine (
    .clk (clk),
    .rst (rst),
    .go  (go),
    .req (in_req),
    .ch  (in_ch),
    .d   (in_data),
    .lvl (in_lvl),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) m_tdata <= {7'b0000000, res};
  end

  assert property (@(posedge clk) disable iff (rst) go |=> m_tvalid)
    else $error("processed word did not reach output");

  assert property (@(posedge clk) disable iff (rst)
    go && res.ack_found |-> (in_req == REQ_ACK || in_req == REQ_RETI))
    else $error("ack_found outside ack/reti");

  assert property (@(posedge clk) disable iff (rst)
    go && res.tx_strobe |-> in_req == REQ_TX_DONE)
    else $error("tx strobe without tx done");

  assert property (@(posedge clk) disable iff (rst)
    go && in_req != REQ_CTRL_WR |-> res.modem_changed == 3'b000)
    else $error("modem change outside control write");

endmodule
